// ===== design/b64sc_pkg.sv =====
// Shared types, constants and alphabet mapping functions for the Base64 stream codec.
// No dependencies; imported by every module of the codec.
`timescale 1ns / 1ps

package b64sc_pkg;

  localparam int unsigned MaxRes = 4;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  localparam logic [7:0] CHAR_PAD = 8'h3D;

  // Results of one input request, entry 0 first
  typedef struct packed {
    logic [2:0]              cnt;
    logic [MaxRes-1:0][7:0]  data;
    logic [MaxRes-1:0]       dv;
    logic                    last;
  } res_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // Bit 6 flags an alphabet character, bits 5:0 carry its value
  function automatic logic [6:0] dec_char(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

// ===== design/base64_stream_codec.sv =====
// Top level of the streaming Base64 codec (standard alphabet, '=' padding).
// Depends on b64sc_pkg, b64sc_xlate and b64sc_outbuf.
//
//   channel   handshake                       payload
//   in        in_item_valid / in_stall        in_byte, in_last
//   out       out_item_valid / out_stall      out_byte, out_valid, out_last
//   cfg       cfg_valid / cfg_ready           cfg_mode
//
// One request is translated combinationally into up to four results, which
// leave through the output register one per cycle while the output is not
// stalled. A request is taken once the buffer holds at most one result about
// to move out.
// Reset (synchronous, rst_n low) selects encode mode and clears the stream.
// A stalled output holds its register and, once the buffer fills, in_stall.
`timescale 1ns / 1ps

module base64_stream_codec import b64sc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_item_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_item_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_mode
);

  res_t res;
  logic can_take;
  logic in_fire;
  logic cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = !can_take;
  assign in_fire   = in_item_valid && can_take;

  b64sc_xlate u_xlate (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_mode (cfg_mode),
    .in_fire  (in_fire),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .res      (res)
  );

  b64sc_outbuf u_outbuf (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .in_fire        (in_fire),
    .can_take       (can_take),
    .out_item_valid (out_item_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .out_last       (out_last)
  );

endmodule

// ===== design/b64sc_xlate.sv =====
// Stream state and single-pass encode/decode translation of one input request.
// Depends on b64sc_pkg.
`timescale 1ns / 1ps

module b64sc_xlate import b64sc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_mode,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output res_t       res
);

  mode_t      mode_r,  mode_nxt;
  logic [11:0] acc_r,  acc_nxt;
  logic [2:0]  held_r, held_nxt;
  logic [1:0]  cmf_r,  cmf_nxt;
  logic        pad_r,  pad_nxt;

  logic [11:0]      t_enc;
  logic [11:0]      t_dec;
  logic [6:0]       dec;
  logic [MaxRes-1:0][5:0] d;
  logic [2:0]       k;
  logic [2:0]       h_enc;
  logic [1:0]       cmf_new;
  logic [1:0]       pad_cnt;

  always_comb begin
    t_enc   = {acc_r[3:0], in_byte};
    dec     = dec_char(in_byte);
    t_dec   = {acc_r[5:0], dec[5:0]};
    d       = '0;
    k       = 3'd1;
    h_enc   = 3'd2;
    res     = '0;
    res.last = in_last;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    held_nxt = held_r;
    cmf_nxt  = cmf_r;
    pad_nxt  = pad_r;
    cmf_new  = cmf_r;
    pad_cnt  = 2'd0;

    if (mode_r == MODE_ENCODE) begin
      case (held_r)
        3'd2: begin
          d[0]  = t_enc[9:4];
          h_enc = 3'd4;
        end
        3'd4: begin
          d[0]  = t_enc[11:6];
          d[1]  = t_enc[5:0];
          k     = 3'd2;
          h_enc = 3'd0;
        end
        default: begin
          d[0]  = t_enc[7:2];
          h_enc = 3'd2;
        end
      endcase
      if (in_last) begin
        case (h_enc)
          3'd2: begin
            d[k[1:0]] = {t_enc[1:0], 4'b0000};
            k = k + 3'd1;
          end
          3'd4: begin
            d[k[1:0]] = {t_enc[3:0], 2'b00};
            k = k + 3'd1;
          end
          default: begin
          end
        endcase
      end
      cmf_new = cmf_r + k[1:0];
      if (in_last) begin
        pad_cnt = 2'd0 - cmf_new;
      end
      res.cnt = k + {1'b0, pad_cnt};
      for (int i = 0; i < MaxRes; i++) begin
        res.dv[i]   = 1'b1;
        res.data[i] = (3'(i) < k) ? enc_char(d[i[1:0]]) : CHAR_PAD;
      end
      acc_nxt  = t_enc;
      held_nxt = h_enc;
      cmf_nxt  = cmf_new;
    end else begin
      if (!pad_r) begin
        if (in_byte == CHAR_PAD) begin
          pad_nxt = 1'b1;
        end else if (dec[6]) begin
          acc_nxt = t_dec;
          case (held_r)
            3'd2: begin
              res.cnt     = 3'd1;
              res.data[0] = t_dec[7:0];
              res.dv[0]   = 1'b1;
              held_nxt    = 3'd0;
            end
            3'd4: begin
              res.cnt     = 3'd1;
              res.data[0] = t_dec[9:2];
              res.dv[0]   = 1'b1;
              held_nxt    = 3'd2;
            end
            3'd6: begin
              res.cnt     = 3'd1;
              res.data[0] = t_dec[11:4];
              res.dv[0]   = 1'b1;
              held_nxt    = 3'd4;
            end
            default: begin
              held_nxt = 3'd6;
            end
          endcase
        end
      end
      if (in_last && res.cnt == 3'd0) begin
        res.cnt = 3'd1;
      end
    end

    if (in_last) begin
      acc_nxt  = '0;
      held_nxt = 3'd0;
      cmf_nxt  = 2'd0;
      pad_nxt  = 1'b0;
    end
    if (cfg_we) begin
      mode_nxt = mode_t'(cfg_mode);
      acc_nxt  = '0;
      held_nxt = 3'd0;
      cmf_nxt  = 2'd0;
      pad_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
      acc_r  <= '0;
      held_r <= 3'd0;
      cmf_r  <= 2'd0;
      pad_r  <= 1'b0;
    end else if (in_fire || cfg_we) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
      cmf_r  <= cmf_nxt;
      pad_r  <= pad_nxt;
    end
  end

endmodule

// ===== design/b64sc_outbuf.sv =====
// Result buffer for one request's results and the registered output stage.
// Depends on b64sc_pkg.
`timescale 1ns / 1ps

module b64sc_outbuf import b64sc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  res_t       res,
  input  logic       in_fire,
  output logic       can_take,
  output logic       out_item_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  logic [MaxRes-1:0][7:0] data_r, data_nxt;
  logic [MaxRes-1:0]      dv_r,   dv_nxt;
  logic [2:0]             cnt_r,  cnt_nxt;
  logic                   last_r, last_nxt;
  logic                   ov_r;
  logic [7:0]             ob_r;
  logic                   odv_r;
  logic                   ol_r;
  logic                   out_free;
  logic                   pop;

  assign out_free = !ov_r || !out_stall;
  assign pop      = (cnt_r != 3'd0) && out_free;
  assign can_take = (cnt_r == 3'd0) || (cnt_r == 3'd1 && pop);

  always_comb begin
    data_nxt = data_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    if (pop) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        data_nxt[i] = data_r[i+1];
        dv_nxt[i]   = dv_r[i+1];
      end
      cnt_nxt = cnt_r - 3'd1;
    end
    if (in_fire) begin
      data_nxt = res.data;
      dv_nxt   = res.dv;
      cnt_nxt  = res.cnt;
      last_nxt = res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 3'd0;
      last_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
      if (out_free) begin
        ov_r <= pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    dv_r   <= dv_nxt;
    if (pop) begin
      ob_r  <= data_r[0];
      odv_r <= dv_r[0];
      ol_r  <= last_r && (cnt_r == 3'd1);
    end
  end

  assign out_item_valid = ov_r;
  assign out_byte       = ob_r;
  assign out_valid      = odv_r;
  assign out_last       = ol_r;

endmodule

// ===== bench/tb_base64_stream_codec.sv =====
// Self-checking bench for base64_stream_codec: directed and random streams in both
// directions, random idling on both channels and one long output hold-off.
// Depends on b64sc_pkg and the codec RTL; needs no other file.
`timescale 1ns / 1ps

module tb_base64_stream_codec;
  import b64sc_pkg::*;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } codec_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       dv;
    logic       last;
  } codec_res_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_item_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_item_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_mode = 1'b0;

  codec_req_t pending_req_q[$];
  codec_res_t codec_out_q[$];
  logic [7:0] raw_q[$];
  logic [7:0] txt_q[$];

  int req_sent = 0;
  int req_taken = 0;
  int err_cnt = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  logic       hold_kick = 1'b0;
  logic [9:0] hold_left = '0;

  // Codec state as the predictor sees it
  mode_t      mode_r = MODE_ENCODE;
  logic [11:0] acc_r;
  int         nbits;
  logic [1:0] quad_cnt;
  bit         pad_hit;

  base64_stream_codec u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_item_valid  (in_item_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_item_valid (out_item_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_mode       (cfg_mode)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    return ALPHABET[8*(63-v) +: 8];
  endfunction

  function automatic int char_val(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (ALPHABET[8*(63-i) +: 8] == c) return i;
    end
    return -1;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (char_val(c) >= 0 || c == CHAR_PAD);
    return c;
  endfunction

  function automatic void clear_stream();
    acc_r = '0;
    nbits = (mode_r == MODE_DECODE) ? -8 : -6;
    quad_cnt = '0;
    pad_hit = 1'b0;
  endfunction

  function automatic void expect_res(input logic [7:0] d, input logic dv);
    codec_out_q.push_back('{data: d, dv: dv, last: 1'b0});
  endfunction

  // Work out every result one accepted request gives
  function automatic void translate_request(input logic [7:0] c, input logic lst);
    int n;
    int held;
    int idx;
    codec_res_t tail;
    n = 0;
    if (mode_r == MODE_ENCODE) begin
      acc_r = {acc_r[3:0], c};
      nbits += 8;
      while (nbits >= 0) begin
        expect_res(sextet_char(6'(acc_r >> nbits)), 1'b1);
        n++;
        nbits -= 6;
        quad_cnt++;
      end
      if (lst) begin
        if (nbits > -6) begin
          held = nbits + 6;
          expect_res(sextet_char(6'(acc_r << (6 - held))), 1'b1);
          n++;
          quad_cnt++;
        end
        while (quad_cnt != 0) begin
          expect_res(CHAR_PAD, 1'b1);
          n++;
          quad_cnt++;
        end
      end
    end else begin
      if (!pad_hit) begin
        if (c == CHAR_PAD) begin
          pad_hit = 1'b1;
        end else begin
          idx = char_val(c);
          if (idx >= 0) begin
            acc_r = {acc_r[5:0], 6'(idx)};
            nbits += 6;
            if (nbits >= 0) begin
              expect_res(8'(acc_r >> nbits), 1'b1);
              n++;
              nbits -= 8;
            end
          end
        end
      end
      if (lst && n == 0) begin
        expect_res(8'h00, 1'b0);
        n++;
      end
    end
    if (lst) begin
      tail = codec_out_q.pop_back();
      tail.last = 1'b1;
      codec_out_q.push_back(tail);
      clear_stream();
    end
  endfunction

  // Sender: hold a stalled request, advance on acceptance
  always @(posedge clk) begin : drv_proc
    logic       nv;
    codec_req_t nr;
    nv = in_item_valid;
    nr = '{data: in_byte, last: in_last};
    if (in_item_valid && !in_stall) begin
      translate_request(nr.data, nr.last);
      req_taken++;
      nv = 1'b0;
    end
    if (!nv && pending_req_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
      nr = pending_req_q.pop_front();
      nv = 1'b1;
    end
    in_item_valid <= nv;
    in_byte <= nr.data;
    in_last <= nr.last;
  end

  always @(posedge clk) begin
    if (hold_kick) begin
      hold_left <= 10'd400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1'b1;
    end
  end

  // Receiver: compare each accepted result with the oldest one awaited
  always @(posedge clk) begin : mon_proc
    codec_res_t want;
    if (out_item_valid && !out_stall) begin
      if (codec_out_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected result: byte %h valid %b last %b",
                   out_byte, out_valid, out_last);
        end
      end else begin
        want = codec_out_q.pop_front();
        if (want.data !== out_byte || want.dv !== out_valid || want.last !== out_last) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch: expected byte %h valid %b last %b, got byte %h valid %b last %b",
                     want.data, want.dv, want.last, out_byte, out_valid, out_last);
          end
        end
      end
    end
    out_stall <= hold_kick || hold_left != 0 || $urandom_range(99) < snk_stall_pct;
  end

  task automatic queue_req(input logic [7:0] c, input logic lst);
    pending_req_q.push_back('{data: c, last: lst});
    req_sent++;
  endtask

  task automatic queue_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_req(s[i], i == s.len() - 1);
    end
  endtask

  task automatic write_mode(input mode_t m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_r = m;
    clear_stream();
  endtask

  task automatic settle();
    while (req_taken != req_sent || codec_out_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic add_raw_stream();
    int len;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      queue_req(rand_byte(), i == len - 1);
    end
  endtask

  // Mostly well-formed text with random content; some noise and broken streams
  task automatic add_text_stream();
    int kind;
    int len;
    int n;
    int k;
    bit noisy;
    logic [23:0] grp;
    kind = $urandom_range(9);
    noisy = ($urandom_range(3) == 0);
    raw_q.delete();
    txt_q.delete();
    if (kind == 7 || kind == 8) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        txt_q.push_back(($urandom_range(5) == 0) ? CHAR_PAD : 8'($urandom_range(255)));
      end
    end else begin
      len = $urandom_range(8);
      for (int i = 0; i < len; i++) raw_q.push_back(rand_byte());
      for (int i = 0; i < len; i += 3) begin
        n = (len - i < 3) ? len - i : 3;
        grp = {raw_q[i], (n > 1) ? raw_q[i+1] : 8'h00, (n > 2) ? raw_q[i+2] : 8'h00};
        for (int j = 0; j <= n; j++) txt_q.push_back(sextet_char(6'(grp >> (18 - 6*j))));
        for (int j = n; j < 3; j++) txt_q.push_back(CHAR_PAD);
      end
      if (kind == 9 && txt_q.size() > 1) begin
        k = $urandom_range(1, txt_q.size() - 1);
        while (txt_q.size() > k) void'(txt_q.pop_back());
      end
      if ($urandom_range(3) == 0) begin
        while (txt_q.size() != 0 && txt_q[txt_q.size()-1] == CHAR_PAD) void'(txt_q.pop_back());
      end
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) txt_q.push_back(8'($urandom_range(255)));
      end
      if (txt_q.size() == 0) txt_q.push_back(8'($urandom_range(255)));
    end
    for (int i = 0; i < txt_q.size(); i++) begin
      if (noisy && $urandom_range(7) == 0) queue_req(junk_char(), 1'b0);
      queue_req(txt_q[i], i == txt_q.size() - 1);
    end
  endtask

  initial begin : stim
    int seg_start;
    mode_t m;
    clear_stream();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(MODE_ENCODE);
    queue_req(8'h00, 1'b1);
    queue_req(8'hFF, 1'b0);
    queue_req(8'hFF, 1'b1);
    queue_req(8'h00, 1'b0);
    queue_req(8'hFF, 1'b0);
    queue_req(8'h80, 1'b1);
    settle();

    write_mode(MODE_DECODE);
    queue_str("TWFu");
    queue_str("TWE=");
    queue_str("TQ=z");
    queue_str("/+9z");
    queue_req(8'h00, 1'b0);
    queue_req("T", 1'b0);
    queue_req(8'hFF, 1'b1);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p / 2)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 51; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 51; end
        default: begin src_idle_pct = 32; snk_stall_pct = 32; end
      endcase
      m = ((p % 2) ^ ((p / 2) % 2)) ? MODE_DECODE : MODE_ENCODE;
      write_mode(m);
      seg_start = req_sent;
      while (req_sent - seg_start < 40) begin
        if (m == MODE_ENCODE) add_raw_stream();
        else add_text_stream();
      end
      // sometimes leave a stream open so the next mode write has state to drop
      if ($urandom_range(1)) begin
        repeat ($urandom_range(1, 3)) queue_req(rand_byte(), 1'b0);
      end
      if (p == 0) begin
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end
      settle();
    end

    if (err_cnt == 0 && codec_out_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
